// ===== rtl/core/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int ADDR_W  = 9;
    localparam int AGE_W   = 16;
    localparam int COUNT_W = 16;

    localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // update command broadcast to every cell
    typedef struct packed {
        logic touch;    // age all frames, clear the referenced one
        logic load;     // map a new page into the referenced frame
    } cell_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_Q,
        ST_DIV_R,
        ST_PAGE,
        ST_SCAN,
        ST_UPDATE
    } ctrl_state_t;

endpackage

// ===== rtl/core/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame slot: holds page and age, forwards the lookup/victim token.
// ----------------------------------------------------------------------------
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int FRAME_W = 4,
    parameter int PAGE_W  = 5,
    parameter int INDEX   = 0
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  logic [FRAME_W-1:0] cmd_frame,
    input  logic [PAGE_W-1:0]  cmd_page,
    input  logic [PAGE_W-1:0]  chain_in_page,
    input  logic               chain_in_hit,
    input  logic [FRAME_W-1:0] chain_in_hit_frame,
    input  logic               chain_in_best_ok,
    input  logic [AGE_W-1:0]   chain_in_best_age,
    input  logic [FRAME_W-1:0] chain_in_best_frame,
    input  logic [PAGE_W-1:0]  chain_in_best_page,
    output logic [PAGE_W-1:0]  chain_out_page,
    output logic               chain_out_hit,
    output logic [FRAME_W-1:0] chain_out_hit_frame,
    output logic               chain_out_best_ok,
    output logic [AGE_W-1:0]   chain_out_best_age,
    output logic [FRAME_W-1:0] chain_out_best_frame,
    output logic [PAGE_W-1:0]  chain_out_best_page
);

    localparam logic [FRAME_W-1:0] MY_FRAME = FRAME_W'(INDEX);

    logic               filled_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [AGE_W-1:0]   age_reg;

    logic [PAGE_W-1:0]  tok_page_reg;
    logic               tok_hit_reg;
    logic [FRAME_W-1:0] tok_hit_frame_reg;
    logic               tok_best_ok_reg;
    logic [AGE_W-1:0]   tok_best_age_reg;
    logic [FRAME_W-1:0] tok_best_frame_reg;
    logic [PAGE_W-1:0]  tok_best_page_reg;

    logic mine;
    logic take;
    logic selected;

    assign mine     = filled_reg && (page_reg == chain_in_page);
    // strict compare keeps ties on the lower index
    assign take     = !chain_in_best_ok || (age_reg > chain_in_best_age);
    assign selected = (cmd_frame == MY_FRAME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            age_reg    <= '0;
        end
        else
        begin
            if (cmd.touch)
            begin
                if (selected)
                    age_reg <= '0;
                else if (age_reg != AGE_MAX)
                    age_reg <= age_reg + AGE_W'(1);
            end
            if (cmd.load && selected)
                filled_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && selected)
            page_reg <= cmd_page;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_hit_reg     <= 1'b0;
            tok_best_ok_reg <= 1'b0;
        end
        else
        begin
            tok_hit_reg     <= chain_in_hit || mine;
            tok_best_ok_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_page_reg      <= chain_in_page;
        tok_hit_frame_reg <= chain_in_hit ? chain_in_hit_frame : MY_FRAME;
        if (take)
        begin
            tok_best_age_reg   <= age_reg;
            tok_best_frame_reg <= MY_FRAME;
            tok_best_page_reg  <= page_reg;
        end
        else
        begin
            tok_best_age_reg   <= chain_in_best_age;
            tok_best_frame_reg <= chain_in_best_frame;
            tok_best_page_reg  <= chain_in_best_page;
        end
    end

    assign chain_out_page       = tok_page_reg;
    assign chain_out_hit        = tok_hit_reg;
    assign chain_out_hit_frame  = tok_hit_frame_reg;
    assign chain_out_best_ok    = tok_best_ok_reg;
    assign chain_out_best_age   = tok_best_age_reg;
    assign chain_out_best_frame = tok_best_frame_reg;
    assign chain_out_best_page  = tok_best_page_reg;

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over a row of frame cells with saturating age counters.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   address
// m_axis    out  hit, frame, evicted_valid, evicted_page, miss_count
//
// Steps: an address is accepted in idle; the page divide/modulo multiplies
// run in the DIV_Q, DIV_R and PAGE states; the token then ripples down the
// cell row, one cell per cycle; the update state loads the output register.
// Reset: ages, fill flags, fault count and frame fill counter clear at once;
// no clearing pass. A new address is taken while a result still waits in
// the output register; a stalled result holds the next access in update.
//
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter  int FRAMES    = 10,
    parameter  int PAGES     = 32,
    parameter  int PAGE_SIZE = 10,
    localparam int FRAME_W   = $clog2(FRAMES),
    localparam int PAGE_W    = $clog2(PAGES),
    localparam int IN_DW     = ((ADDR_W + 7) / 8) * 8,
    localparam int OUT_W     = 2 + FRAME_W + PAGE_W + COUNT_W,
    localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_DW-1:0]    s_axis_tdata,   // address
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_DW-1:0]   m_axis_tdata    // hit, frame, evicted_valid,
                                                // evicted_page, miss_count
);

    localparam int USED_W  = $clog2(FRAMES + 1);

    // address / PAGE_SIZE by reciprocal multiply, exact for ADDR_W-bit inputs
    localparam int DIV_SHIFT = ADDR_W + $clog2(PAGE_SIZE);
    localparam int DIV_MW    = DIV_SHIFT + 1;
    localparam int DIV_PW    = ADDR_W + DIV_MW;
    localparam logic [DIV_MW-1:0] DIV_MULT =
        DIV_MW'(((64'd1 << DIV_SHIFT) + 64'(PAGE_SIZE) - 64'd1) / 64'(PAGE_SIZE));

    // quotient / PAGES, same scheme, for the modulo
    localparam int MOD_SHIFT = ADDR_W + $clog2(PAGES);
    localparam int MOD_MW    = MOD_SHIFT + 1;
    localparam int MOD_PW    = ADDR_W + MOD_MW;
    localparam logic [MOD_MW-1:0] MOD_MULT =
        MOD_MW'(((64'd1 << MOD_SHIFT) + 64'(PAGES) - 64'd1) / 64'(PAGES));

    localparam logic [USED_W-1:0]  USED_FULL = USED_W'(FRAMES);
    localparam logic [USED_W-1:0]  SCAN_LAST = USED_W'(FRAMES - 1);

    ctrl_state_t state_reg, state_next;

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  quot_reg;
    logic [ADDR_W-1:0]  wrap_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [USED_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [COUNT_W-1:0] miss_reg, miss_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_ev_valid_reg;
    logic [PAGE_W-1:0]  out_ev_page_reg;
    logic [COUNT_W-1:0] out_miss_reg;

    logic               res_load;
    logic               res_hit;
    logic [FRAME_W-1:0] res_frame;
    logic               res_ev_valid;
    logic [PAGE_W-1:0]  res_ev_page;

    logic [DIV_PW-1:0]  div_prod;
    logic [MOD_PW-1:0]  mod_prod;
    logic [ADDR_W-1:0]  wrap_times;

    cell_cmd_t          cmd;
    logic [FRAME_W-1:0] cmd_frame;

    // token lanes between cells; entry 0 is the row's input
    logic [PAGE_W-1:0]  ch_page       [FRAMES+1];
    logic               ch_hit        [FRAMES+1];
    logic [FRAME_W-1:0] ch_hit_frame  [FRAMES+1];
    logic               ch_best_ok    [FRAMES+1];
    logic [AGE_W-1:0]   ch_best_age   [FRAMES+1];
    logic [FRAME_W-1:0] ch_best_frame [FRAMES+1];
    logic [PAGE_W-1:0]  ch_best_page  [FRAMES+1];

    assign ch_page[0]       = page_reg;
    assign ch_hit[0]        = 1'b0;
    assign ch_hit_frame[0]  = '0;
    assign ch_best_ok[0]    = 1'b0;
    assign ch_best_age[0]   = '0;
    assign ch_best_frame[0] = '0;
    assign ch_best_page[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            lrupr_cell #(
                .FRAME_W (FRAME_W),
                .PAGE_W  (PAGE_W),
                .INDEX   (gi)
            ) u_cell (
                .clk                  (clk),
                .rst_n                (rst_n),
                .cmd                  (cmd),
                .cmd_frame            (cmd_frame),
                .cmd_page             (page_reg),
                .chain_in_page        (ch_page[gi]),
                .chain_in_hit         (ch_hit[gi]),
                .chain_in_hit_frame   (ch_hit_frame[gi]),
                .chain_in_best_ok     (ch_best_ok[gi]),
                .chain_in_best_age    (ch_best_age[gi]),
                .chain_in_best_frame  (ch_best_frame[gi]),
                .chain_in_best_page   (ch_best_page[gi]),
                .chain_out_page       (ch_page[gi+1]),
                .chain_out_hit        (ch_hit[gi+1]),
                .chain_out_hit_frame  (ch_hit_frame[gi+1]),
                .chain_out_best_ok    (ch_best_ok[gi+1]),
                .chain_out_best_age   (ch_best_age[gi+1]),
                .chain_out_best_frame (ch_best_frame[gi+1]),
                .chain_out_best_page  (ch_best_page[gi+1])
            );
        end
    endgenerate

    // page arithmetic, one multiply per cycle
    assign div_prod   = DIV_PW'(addr_reg) * DIV_PW'(DIV_MULT);
    assign mod_prod   = MOD_PW'(quot_reg) * MOD_PW'(MOD_MULT);
    assign wrap_times = ADDR_W'(wrap_reg * ADDR_W'(PAGES));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
            addr_reg <= s_axis_tdata[ADDR_W-1:0];
        if (state_reg == ST_DIV_Q)
            quot_reg <= div_prod[DIV_SHIFT +: ADDR_W];
        if (state_reg == ST_DIV_R)
            wrap_reg <= mod_prod[MOD_SHIFT +: ADDR_W];
        if (state_reg == ST_PAGE)
            page_reg <= PAGE_W'(quot_reg - wrap_times);
    end

    // resolve the access from the token at the end of the row
    always_comb
    begin
        res_hit      = ch_hit[FRAMES];
        res_frame    = ch_hit_frame[FRAMES];
        res_ev_valid = 1'b0;
        res_ev_page  = '0;
        res_load     = 1'b0;
        used_next    = used_reg;
        miss_next    = miss_reg;
        if (!ch_hit[FRAMES])
        begin
            res_load = 1'b1;
            if (miss_reg != COUNT_MAX)
                miss_next = miss_reg + COUNT_W'(1);
            if (used_reg < USED_FULL)
            begin
                // free frames fill in index order
                res_frame = used_reg[FRAME_W-1:0];
                used_next = used_reg + USED_W'(1);
            end
            else
            begin
                res_frame    = ch_best_frame[FRAMES];
                res_ev_valid = 1'b1;
                res_ev_page  = ch_best_page[FRAMES];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd_frame      = res_frame;
        s_axis_tready  = 1'b0;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = ST_DIV_Q;
            end
            ST_DIV_Q:
                state_next = ST_DIV_R;
            ST_DIV_R:
                state_next = ST_PAGE;
            ST_PAGE:
            begin
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + USED_W'(1);
                if (scan_cnt_reg == SCAN_LAST)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.touch      = 1'b1;
                    cmd.load       = res_load;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            used_reg      <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cmd.touch)
            begin
                used_reg <= used_next;
                miss_reg <= miss_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.touch)
        begin
            out_hit_reg      <= res_hit;
            out_frame_reg    <= res_frame;
            out_ev_valid_reg <= res_ev_valid;
            out_ev_page_reg  <= res_ev_page;
            out_miss_reg     <= miss_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'({out_miss_reg, out_ev_page_reg, out_ev_valid_reg,
                                    out_frame_reg, out_hit_reg});

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_hit_reg |-> !out_ev_valid_reg)
        else $error("hit result carries an eviction");

    // eviction only once every frame holds a page
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.touch && res_ev_valid |-> used_reg == USED_FULL)
        else $error("eviction with a free frame left");

    // fill counter never runs past the frame count
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_FULL)
        else $error("frame fill counter overflow");

    // fault count only grows
    a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> miss_reg >= $past(miss_reg))
        else $error("fault count decreased");

    // the token at the row end is complete when the update runs
    a_token_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |-> ch_best_ok[FRAMES] && ch_page[FRAMES] == page_reg)
        else $error("update before token reached the row end");

endmodule

// ===== tb/lru_page_replacement_checker.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_checker
// Watches both stream channels of the LRU page replacement block, keeps its
// own frame table to work out each lookup result, and compares every output
// beat with the oldest expected lookup.
// ----------------------------------------------------------------------------
module lru_page_replacement_checker
    import lrupr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // address
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // hit, frame, evicted_valid,
                                        // evicted_page, miss_count
    output int          errors,
    output int          outstanding
);

    localparam int FRAMES    = 10;
    localparam int PAGES     = 32;
    localparam int PAGE_SIZE = 10;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic         hit;
        logic [3:0]   frame;
        logic         evicted_valid;
        logic [4:0]   evicted_page;
        logic [15:0]  miss_count;
    } lookup_t;

    // shadow frame table
    logic [4:0]         frame_page    [FRAMES];
    logic [AGE_W-1:0]   frame_age     [FRAMES];
    logic               page_resident [PAGES];
    logic [3:0]         page_frame    [PAGES];
    int                 frames_used;
    logic [COUNT_W-1:0] fault_total;

    lookup_t expected_lookups[$];

    // one access: lookup, fill or evict, then age update
    task automatic page_access(input logic [8:0] addr, output lookup_t r);
        int page;
        int victim;
        page = (int'(addr) / PAGE_SIZE) % PAGES;
        r = '0;
        if (page_resident[page])
        begin
            r.hit   = 1'b1;
            r.frame = page_frame[page];
        end
        else
        begin
            if (frames_used < FRAMES)
            begin
                r.frame = 4'(frames_used);
                frames_used++;
            end
            else
            begin
                // oldest frame, ties to the lowest index
                victim = 0;
                for (int i = 1; i < FRAMES; i++)
                    if (frame_age[i] > frame_age[victim])
                        victim = i;
                r.frame         = 4'(victim);
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_page[victim];
                page_resident[frame_page[victim]] = 1'b0;
            end
            frame_page[r.frame] = 5'(page);
            page_frame[page]    = r.frame;
            page_resident[page] = 1'b1;
            if (fault_total != COUNT_MAX)
                fault_total++;
        end
        for (int i = 0; i < FRAMES; i++)
            if (frame_age[i] != AGE_MAX)
                frame_age[i]++;
        frame_age[r.frame] = '0;
        r.miss_count = fault_total;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        lookup_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page[i] = '0;
                frame_age[i]  = '0;
            end
            for (int i = 0; i < PAGES; i++)
            begin
                page_resident[i] = 1'b0;
                page_frame[i]    = '0;
            end
            frames_used = 0;
            fault_total = '0;
            expected_lookups.delete();
            errors      = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit           = m_axis_tdata[0];
                got.frame         = m_axis_tdata[4:1];
                got.evicted_valid = m_axis_tdata[5];
                got.evicted_page  = m_axis_tdata[10:6];
                got.miss_count    = m_axis_tdata[26:11];
                if (expected_lookups.size() == 0)
                begin
                    if (errors < MAX_SHOWN)
                        $display("unexpected output beat: hit=%0d frame=%0d ev=%0d/%0d miss=%0d",
                                 got.hit, got.frame, got.evicted_valid,
                                 got.evicted_page, got.miss_count);
                    errors++;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (got !== want)
                    begin
                        if (errors < MAX_SHOWN)
                        begin
                            $write("lookup mismatch: exp hit=%0d frame=%0d ev=%0d/%0d miss=%0d, ",
                                   want.hit, want.frame, want.evicted_valid,
                                   want.evicted_page, want.miss_count);
                            $display("got hit=%0d frame=%0d ev=%0d/%0d miss=%0d",
                                     got.hit, got.frame, got.evicted_valid,
                                     got.evicted_page, got.miss_count);
                        end
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                page_access(s_axis_tdata[8:0], want);
                expected_lookups.push_back(want);
            end
            outstanding = expected_lookups.size();
        end
    end

endmodule

// ===== tb/tb_lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// tb_lru_page_replacement
// Drives address beats into the LRU page replacement block under varying
// sender and receiver idling, with long output stalls and full drains,
// and takes the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

    localparam int IN_DW       = 16;
    localparam int OUT_DW      = 32;
    localparam int RANDOM_BEATS = 1280;
    localparam int HOT_PAGES   = 13;
    localparam int LONG_HOLD   = 150;   // receiver hold-off, cycles
    localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
    localparam int DRAIN_WAIT  = 40;    // extra wait after the final drain

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_DW-1:0]   s_axis_tdata;   // address
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_DW-1:0]  m_axis_tdata;   // hit, frame, evicted_valid,
                                        // evicted_page, miss_count

    int errors;
    int outstanding;

    // idle odds in percent, set per phase by the stimulus process
    int tx_idle_pct;
    int rx_idle_pct;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int hold_req;

    int quiet_cycles;

    lru_page_replacement dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lru_page_replacement_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Sender side. A beat is offered after a random number of idle cycles;
    // valid stays high straight into the next beat when no gap is drawn, so
    // valid only ever gets one assignment per edge.
    task automatic send_address(input logic [8:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DW-9){1'b0}}, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Wait until the block has handed back every outstanding lookup.
    task automatic drain_lookups();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver side: random ready, or a long hold-off on request.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen     = hold_req;
                hold_left     = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [8:0] directed_addrs[$];
        logic [4:0] hot[HOT_PAGES];
        logic [8:0] addr;
        logic [8:0] last_addr;
        int         sel;
        int         phase_len;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_req      = 0;
        last_addr     = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: address extremes, aliasing of pages beyond the table,
        // filling all ten frames, then hits and evictions of the oldest page.
        directed_addrs = '{9'd0, 9'd511, 9'd319, 9'd320, 9'd9, 9'd10,
                           9'd100, 9'd200, 9'd250, 9'd290, 9'd300, 9'd150,
                           9'd160, 9'd511, 9'd0, 9'd490, 9'd170, 9'd255,
                           9'd256, 9'd170, 9'd5, 9'd480, 9'd479, 9'd1, 9'd318};
        foreach (directed_addrs[i])
            send_address(directed_addrs[i]);
        drain_lookups();

        // Random: three idling phases; most beats come from a shifting hot
        // set of pages so that hits and LRU evictions both stay frequent.
        phase_len = RANDOM_BEATS / 3;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == 0)
            begin
                tx_idle_pct = 19;
                rx_idle_pct = 47;
            end
            else if (n == phase_len)
            begin
                drain_lookups();
                tx_idle_pct = 47;
                rx_idle_pct = 19;
            end
            else if (n == 2 * phase_len)
            begin
                drain_lookups();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // long output stall while the sender keeps offering beats
            if (n == 100 || n == 2 * phase_len + 50)
                hold_req++;

            if (n % 200 == 0)
                foreach (hot[i])
                    hot[i] = 5'($urandom_range(0, 31));

            sel = $urandom_range(0, 99);
            if (sel < 65)
            begin
                addr = 9'(hot[$urandom_range(0, HOT_PAGES - 1)] * 10
                          + $urandom_range(0, 9));
                // same page seen through the aliased upper address range
                if ($urandom_range(0, 5) == 0 && addr <= 9'd191)
                    addr = addr + 9'd320;
            end
            else if (sel < 90)
                addr = 9'($urandom_range(0, 511));
            else
                addr = last_addr;
            last_addr = addr;
            send_address(addr);
        end

        drain_lookups();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== lru_page_replacement.f =====
rtl/core/lrupr_pkg.sv
rtl/core/lrupr_cell.sv
rtl/core/lru_page_replacement.sv
tb/lru_page_replacement_checker.sv
tb/tb_lru_page_replacement.sv
